// ----- rtl/tdbl_pkg.sv -----
// ----------------------------------------------------------------------------
// tdbl_pkg
// Shared types and constants for the tree distance block: field widths,
// operation codes, read address selects and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tdbl_pkg;

   localparam int NodesDef  = 1024;
   localparam int LevelsDef = 10;

   localparam int OpW    = 2;
   localparam int IdW    = 10;
   localparam int DepthW = 10;
   localparam int DistW  = 11;

   localparam logic [OpW-1:0] OP_LOAD  = 2'd0;
   localparam logic [OpW-1:0] OP_BUILD = 2'd1;
   localparam logic [OpW-1:0] OP_QUERY = 2'd2;

   // Ancestor table read address selects.
   localparam logic [2:0] AR_BUILD_N = 3'd0;
   localparam logic [2:0] AR_BUILD_T = 3'd1;
   localparam logic [2:0] AR_A       = 3'd2;
   localparam logic [2:0] AR_B       = 3'd3;
   localparam logic [2:0] AR_A0      = 3'd4;

   // Depth table read address selects.
   localparam logic [1:0] DR_A = 2'd0;
   localparam logic [1:0] DR_B = 2'd1;
   localparam logic [1:0] DR_L = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       anc_we;
      logic       build_wr;
      logic [2:0] ar_sel;
      logic [1:0] dr_sel;
      logic       dep_we;
      logic       node_clr;
      logic       node_inc;
      logic       lvl_zero;
      logic       lvl_one;
      logic       lvl_top;
      logic       lvl_inc;
      logic       lvl_dec;
      logic       load_da;
      logic       load_db;
      logic       lift_a;
      logic       store_ua;
      logic       twin_upd;
      logic       l_from_a;
      logic       l_from_ram;
      logic       load_dl;
      logic       rsp_load;
   } tdbl_cmd_type;

   typedef struct packed {
      logic diff_bit;
      logic lvl_last;
      logic lvl_is_zero;
      logic node_last;
      logic a_eq_b;
      logic out_free;
      logic multi_level;
   } tdbl_sts_type;

endpackage

// ----- rtl/tdbl_req_if.sv -----
// ----------------------------------------------------------------------------
// tdbl_req_if
// Request channel: operation code, two node ids and a node depth.
// ----------------------------------------------------------------------------
interface tdbl_req_if;
   logic                         valid;
   logic                         ready;
   logic [tdbl_pkg::OpW-1:0]     op;
   logic [tdbl_pkg::IdW-1:0]     node_a;
   logic [tdbl_pkg::IdW-1:0]     node_b;
   logic [tdbl_pkg::DepthW-1:0]  node_depth;

   modport source (output valid, output op, output node_a, output node_b,
                   output node_depth, input ready);
   modport sink (input valid, input op, input node_a, input node_b,
                 input node_depth, output ready);
endinterface

// ----- rtl/tdbl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// tdbl_rsp_if
// Response channel: lowest common ancestor and path length of a query.
// ----------------------------------------------------------------------------
interface tdbl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tdbl_pkg::IdW-1:0]   ancestor;
   logic [tdbl_pkg::DistW-1:0] distance;

   modport source (output valid, output ancestor, output distance, input ready);
   modport sink (input valid, input ancestor, input distance, output ready);
endinterface

// ----- rtl/tdbl_ram.sv -----
// ----------------------------------------------------------------------------
// tdbl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tdbl_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tdbl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdbl_ctrl
// Sequencer for load, table build and distance query transactions.
// ----------------------------------------------------------------------------
module tdbl_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [tdbl_pkg::OpW-1:0]     req_op,
   output logic                         req_ready,
   input  tdbl_pkg::tdbl_sts_type       sts,
   output tdbl_pkg::tdbl_cmd_type       cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LOAD   = 5'd1;
   localparam logic [4:0] S_B_N    = 5'd2;
   localparam logic [4:0] S_B_T    = 5'd3;
   localparam logic [4:0] S_B_W    = 5'd4;
   localparam logic [4:0] S_Q_DA   = 5'd5;
   localparam logic [4:0] S_Q_DB   = 5'd6;
   localparam logic [4:0] S_Q_SW   = 5'd7;
   localparam logic [4:0] S_LIFT   = 5'd8;
   localparam logic [4:0] S_LIFT_W = 5'd9;
   localparam logic [4:0] S_CHK    = 5'd10;
   localparam logic [4:0] S_TW_A   = 5'd11;
   localparam logic [4:0] S_TW_B   = 5'd12;
   localparam logic [4:0] S_TW_C   = 5'd13;
   localparam logic [4:0] S_FIN_A  = 5'd14;
   localparam logic [4:0] S_FIN_B  = 5'd15;
   localparam logic [4:0] S_DL_A   = 5'd16;
   localparam logic [4:0] S_DL_B   = 5'd17;
   localparam logic [4:0] S_OUT    = 5'd18;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_op)
                  tdbl_pkg::OP_LOAD: begin
                     state_in = S_LOAD;
                  end
                  tdbl_pkg::OP_BUILD: begin
                     if (sts.multi_level) begin
                        cmd.node_clr = 1'b1;
                        cmd.lvl_one  = 1'b1;
                        state_in     = S_B_N;
                     end
                  end
                  tdbl_pkg::OP_QUERY: begin
                     state_in = S_Q_DA;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_LOAD: begin
            cmd.anc_we = 1'b1;
            cmd.dep_we = 1'b1;
            state_in   = S_IDLE;
         end
         S_B_N: begin
            cmd.ar_sel = tdbl_pkg::AR_BUILD_N;
            state_in   = S_B_T;
         end
         S_B_T: begin
            cmd.ar_sel = tdbl_pkg::AR_BUILD_T;
            state_in   = S_B_W;
         end
         S_B_W: begin
            cmd.anc_we   = 1'b1;
            cmd.build_wr = 1'b1;
            state_in     = S_B_N;
            if (sts.node_last) begin
               if (sts.lvl_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.node_clr = 1'b1;
                  cmd.lvl_inc  = 1'b1;
               end
            end else begin
               cmd.node_inc = 1'b1;
            end
         end
         S_Q_DA: begin
            cmd.dr_sel = tdbl_pkg::DR_A;
            state_in   = S_Q_DB;
         end
         S_Q_DB: begin
            cmd.dr_sel  = tdbl_pkg::DR_B;
            cmd.load_da = 1'b1;
            state_in    = S_Q_SW;
         end
         S_Q_SW: begin
            cmd.load_db  = 1'b1;
            cmd.lvl_zero = 1'b1;
            state_in     = S_LIFT;
         end
         S_LIFT: begin
            cmd.ar_sel = tdbl_pkg::AR_A;
            if (sts.diff_bit) begin
               state_in = S_LIFT_W;
            end else if (sts.lvl_last) begin
               state_in = S_CHK;
            end else begin
               cmd.lvl_inc = 1'b1;
            end
         end
         S_LIFT_W: begin
            cmd.lift_a = 1'b1;
            if (sts.lvl_last) begin
               state_in = S_CHK;
            end else begin
               cmd.lvl_inc = 1'b1;
               state_in    = S_LIFT;
            end
         end
         S_CHK: begin
            if (sts.a_eq_b) begin
               cmd.l_from_a = 1'b1;
               state_in     = S_DL_A;
            end else begin
               cmd.lvl_top = 1'b1;
               state_in    = S_TW_A;
            end
         end
         S_TW_A: begin
            cmd.ar_sel = tdbl_pkg::AR_A;
            state_in   = S_TW_B;
         end
         S_TW_B: begin
            cmd.ar_sel   = tdbl_pkg::AR_B;
            cmd.store_ua = 1'b1;
            state_in     = S_TW_C;
         end
         S_TW_C: begin
            cmd.twin_upd = 1'b1;
            if (sts.lvl_is_zero) begin
               state_in = S_FIN_A;
            end else begin
               cmd.lvl_dec = 1'b1;
               state_in    = S_TW_A;
            end
         end
         S_FIN_A: begin
            cmd.ar_sel = tdbl_pkg::AR_A0;
            state_in   = S_FIN_B;
         end
         S_FIN_B: begin
            cmd.l_from_ram = 1'b1;
            state_in       = S_DL_A;
         end
         S_DL_A: begin
            cmd.dr_sel = tdbl_pkg::DR_L;
            state_in   = S_DL_B;
         end
         S_DL_B: begin
            cmd.load_dl = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/tdbl_dp.sv -----
// ----------------------------------------------------------------------------
// tdbl_dp
// Datapath: ancestor and depth tables, node and level counters, query
// registers and the response output register.
// ----------------------------------------------------------------------------
module tdbl_dp #(
   parameter int NODES  = tdbl_pkg::NodesDef,
   parameter int LEVELS = tdbl_pkg::LevelsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tdbl_pkg::IdW-1:0]     req_node_a,
   input  logic [tdbl_pkg::IdW-1:0]     req_node_b,
   input  logic [tdbl_pkg::DepthW-1:0]  req_node_depth,
   input  tdbl_pkg::tdbl_cmd_type       cmd,
   output tdbl_pkg::tdbl_sts_type       sts,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [tdbl_pkg::IdW-1:0]     rsp_ancestor,
   output logic [tdbl_pkg::DistW-1:0]   rsp_distance
);

   localparam int NW      = $clog2(NODES);
   localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ENTRIES = NODES * LEVELS;
   localparam int AW      = $clog2(ENTRIES);
   localparam int DW      = tdbl_pkg::DepthW;
   localparam int XW      = tdbl_pkg::DistW;

   function automatic logic [NW-1:0] clamp_node(input logic [tdbl_pkg::IdW-1:0] id);
      logic [16:0] wide;
      wide = 17'(id);
      if (wide >= 17'(NODES)) begin
         return NW'(NODES - 1);
      end
      return NW'(id);
   endfunction

   function automatic logic [AW-1:0] entry_addr(input logic [NW-1:0] node,
                                                input logic [LW-1:0] lvl);
      return AW'(AW'(node) * AW'(LEVELS)) + AW'(lvl);
   endfunction

   logic [NW-1:0] a_ff, b_ff, ua_ff, l_ff, node_ff;
   logic [DW-1:0] depth_ff, da_ff, db_ff, dl_ff, diff_ff;
   logic [LW-1:0] lvl_ff, lvl_prev;

   logic          rsp_valid_ff;
   logic [tdbl_pkg::IdW-1:0] rsp_anc_ff;
   logic [XW-1:0] rsp_dist_ff;

   logic          anc_we;
   logic [AW-1:0] anc_waddr, anc_raddr;
   logic [NW-1:0] anc_wdata, anc_rdata;
   logic [NW-1:0] dep_raddr;
   logic [DW-1:0] dep_rdata;

   assign lvl_prev = LW'(lvl_ff - LW'(1));

   always_comb begin
      case (cmd.ar_sel)
         tdbl_pkg::AR_BUILD_N: anc_raddr = entry_addr(node_ff, lvl_prev);
         tdbl_pkg::AR_BUILD_T: anc_raddr = entry_addr(anc_rdata, lvl_prev);
         tdbl_pkg::AR_A:       anc_raddr = entry_addr(a_ff, lvl_ff);
         tdbl_pkg::AR_B:       anc_raddr = entry_addr(b_ff, lvl_ff);
         tdbl_pkg::AR_A0:      anc_raddr = entry_addr(a_ff, '0);
         default:              anc_raddr = entry_addr(a_ff, lvl_ff);
      endcase
      case (cmd.dr_sel)
         tdbl_pkg::DR_A: dep_raddr = a_ff;
         tdbl_pkg::DR_B: dep_raddr = b_ff;
         tdbl_pkg::DR_L: dep_raddr = l_ff;
         default:        dep_raddr = a_ff;
      endcase
   end

   assign anc_we    = cmd.anc_we;
   assign anc_waddr = cmd.build_wr ? entry_addr(node_ff, lvl_ff) : entry_addr(a_ff, '0);
   assign anc_wdata = cmd.build_wr ? anc_rdata : b_ff;

   tdbl_ram #(
      .WIDTH (NW),
      .DEPTH (ENTRIES)
   ) u_anc_ram (
      .clock (clock),
      .we    (anc_we),
      .waddr (anc_waddr),
      .wdata (anc_wdata),
      .raddr (anc_raddr),
      .rdata (anc_rdata)
   );

   tdbl_ram #(
      .WIDTH (DW),
      .DEPTH (NODES)
   ) u_dep_ram (
      .clock (clock),
      .we    (cmd.dep_we),
      .waddr (a_ff),
      .wdata (depth_ff),
      .raddr (dep_raddr),
      .rdata (dep_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff     <= clamp_node(req_node_a);
         b_ff     <= clamp_node(req_node_b);
         depth_ff <= req_node_depth;
      end else if (cmd.load_db && (da_ff < dep_rdata)) begin
         a_ff <= b_ff;
         b_ff <= a_ff;
      end else if (cmd.lift_a) begin
         a_ff <= anc_rdata;
      end else if (cmd.twin_upd && (ua_ff != anc_rdata)) begin
         a_ff <= ua_ff;
         b_ff <= anc_rdata;
      end

      if (cmd.load_da) begin
         da_ff <= dep_rdata;
      end
      if (cmd.load_db) begin
         if (da_ff < dep_rdata) begin
            da_ff   <= dep_rdata;
            db_ff   <= da_ff;
            diff_ff <= DW'(dep_rdata - da_ff);
         end else begin
            db_ff   <= dep_rdata;
            diff_ff <= DW'(da_ff - dep_rdata);
         end
      end
      if (cmd.store_ua) begin
         ua_ff <= anc_rdata;
      end
      if (cmd.l_from_a) begin
         l_ff <= a_ff;
      end else if (cmd.l_from_ram) begin
         l_ff <= anc_rdata;
      end
      if (cmd.load_dl) begin
         dl_ff <= dep_rdata;
      end

      if (cmd.node_clr) begin
         node_ff <= '0;
      end else if (cmd.node_inc) begin
         node_ff <= NW'(node_ff + NW'(1));
      end

      if (cmd.lvl_zero) begin
         lvl_ff <= '0;
      end else if (cmd.lvl_one) begin
         lvl_ff <= LW'(1);
      end else if (cmd.lvl_top) begin
         lvl_ff <= LW'(LEVELS - 1);
      end else if (cmd.lvl_inc) begin
         lvl_ff <= LW'(lvl_ff + LW'(1));
      end else if (cmd.lvl_dec) begin
         lvl_ff <= lvl_prev;
      end

      if (cmd.rsp_load) begin
         rsp_anc_ff  <= tdbl_pkg::IdW'(l_ff);
         rsp_dist_ff <= XW'(XW'(da_ff) + XW'(db_ff) - (XW'(dl_ff) << 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.diff_bit    = |(diff_ff & (DW'(1) << lvl_ff));
   assign sts.lvl_last    = (lvl_ff == LW'(LEVELS - 1));
   assign sts.lvl_is_zero = (lvl_ff == '0);
   assign sts.node_last   = (node_ff == NW'(NODES - 1));
   assign sts.a_eq_b      = (a_ff == b_ff);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;
   assign sts.multi_level = (LEVELS > 1);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;
   assign rsp_distance = rsp_dist_ff;

endmodule

// ----- rtl/tree_distance_by_binary_lifting_top.sv -----
// ----------------------------------------------------------------------------
// tree_distance_by_binary_lifting_top
// Lowest common ancestor and path length in a rooted tree, binary lifting.
// ----------------------------------------------------------------------------
// The request channel carries one transaction per operation. A load writes a
// node's parent and depth. A build fills every ancestor level above the
// parents one table entry at a time, as the ancestor RAM has a single read
// port: it reads the node's entry one level down, then that ancestor's entry
// one level down, then writes it. A query reads both depths, lifts the deeper
// node level by level through the ancestor RAM, then lifts both nodes from
// the top level down, a twin lift skipped when the lifted node already equals
// the other one, and last reads the ancestor's depth. Loads and builds give
// no response; an unused op code is accepted and dropped.
// One transaction is handled at a time; req ready is high only while idle.
// The response sits in an output register, so the block takes further loads
// and builds while a response waits; a query that finishes while the
// receiver stalls holds until the previous response is taken.
// Reset clears the sequencer and the response valid. The tables are not
// cleared: nodes must be loaded, and the table built, before being queried.
// ----------------------------------------------------------------------------
module tree_distance_by_binary_lifting_top #(
   parameter int NODES  = tdbl_pkg::NodesDef,
   parameter int LEVELS = tdbl_pkg::LevelsDef
) (
   input logic         clock,
   input logic         reset,
   tdbl_req_if.sink    req_chan,
   tdbl_rsp_if.source  rsp_chan
);

   tdbl_pkg::tdbl_cmd_type cmd;
   tdbl_pkg::tdbl_sts_type sts;

   tdbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tdbl_dp #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_node_a     (req_chan.node_a),
      .req_node_b     (req_chan.node_b),
      .req_node_depth (req_chan.node_depth),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_ancestor   (rsp_chan.ancestor),
      .rsp_distance   (rsp_chan.distance)
   );

endmodule

// ----- verif/tb_tree_distance_by_binary_lifting_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tree_distance_by_binary_lifting_top
// Self-checking bench for the binary lifting tree distance block.
// ----------------------------------------------------------------------------
// A whole tree is loaded and the ancestor table built, followed by directed
// queries and three phases of queries mixed with stray loads, unused op codes
// and one rebuild each. A predictor updated on every accepted request
// transaction holds the expected lowest common ancestor and distance of each
// query, and response transactions are checked against them in order. The
// phases vary how often the sender and the receiver stall.
// ----------------------------------------------------------------------------
module tb_tree_distance_by_binary_lifting_top;

   localparam int NODE_COUNT  = tdbl_pkg::NodesDef;
   localparam int LEVEL_COUNT = tdbl_pkg::LevelsDef;
   localparam int BUILD_CYCLES = 1 + 3 * NODE_COUNT * (LEVEL_COUNT - 1);
   localparam int QUIET_LIMIT  = 4 * BUILD_CYCLES;
   localparam int TAIL_CYCLES  = 4 * (5 * LEVEL_COUNT + 10);

   localparam logic [tdbl_pkg::OpW-1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] MODE_SLOW_RX = 2'd0;
   localparam logic [1:0] MODE_SLOW_TX = 2'd1;
   localparam logic [1:0] MODE_FULL    = 2'd2;

   localparam int SHAPE_MIXED = 0;
   localparam int SHAPE_PATH  = 1;
   localparam int SHAPE_BUSHY = 2;

   typedef struct packed {
      logic [tdbl_pkg::OpW-1:0]    op;
      logic [tdbl_pkg::IdW-1:0]    node_a;
      logic [tdbl_pkg::IdW-1:0]    node_b;
      logic [tdbl_pkg::DepthW-1:0] node_depth;
      logic [1:0]                  mode;
      logic                        hold;
   } tree_op_type;

   typedef struct packed {
      logic [tdbl_pkg::IdW-1:0]   ancestor;
      logic [tdbl_pkg::DistW-1:0] distance;
   } path_type;

   logic clock;
   logic reset;

   tdbl_req_if req_bus ();
   tdbl_rsp_if rsp_bus ();

   tree_distance_by_binary_lifting_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Predicted contents of the block.
   logic [tdbl_pkg::IdW-1:0]    lift_tab [NODE_COUNT][LEVEL_COUNT];
   logic [tdbl_pkg::DepthW-1:0] depth_of [NODE_COUNT];

   // Tree being generated for stimulus.
   logic [tdbl_pkg::IdW-1:0]    up_of    [NODE_COUNT];
   logic [tdbl_pkg::DepthW-1:0] level_of [NODE_COUNT];
   logic [tdbl_pkg::IdW-1:0]    order    [NODE_COUNT];
   logic [tdbl_pkg::IdW-1:0]    tree_root;
   logic [tdbl_pkg::IdW-1:0]    tree_deep;
   logic                        built_once;

   tree_op_type pending_ops [$];
   path_type    expected_paths [$];
   tree_op_type next_op;
   path_type    want_path;
   logic [1:0]  fill_mode;
   logic        fill_hold;

   int unsigned issued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned fault_count    = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned send_idle      = 23;
   int unsigned recv_idle      = 54;

   function automatic void rebuild_lift_table();
      for (int k = 1; k < LEVEL_COUNT; k++)
         for (int n = 0; n < NODE_COUNT; n++)
            lift_tab[n][k] = lift_tab[lift_tab[n][k-1]][k-1];
   endfunction

   function automatic path_type lca_and_distance(input logic [tdbl_pkg::IdW-1:0] a_in,
                                                 input logic [tdbl_pkg::IdW-1:0] b_in);
      logic [tdbl_pkg::IdW-1:0]    hi, lo, ua, ub, meet;
      logic [tdbl_pkg::DepthW-1:0] gap;
      path_type                    res;
      hi = a_in;
      lo = b_in;
      if (depth_of[a_in] < depth_of[b_in]) begin
         hi = b_in;
         lo = a_in;
      end
      gap = depth_of[hi] - depth_of[lo];
      for (int k = 0; k < LEVEL_COUNT; k++)
         if (gap[k]) hi = lift_tab[hi][k];
      if (hi == lo) begin
         meet = hi;
      end else begin
         for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
            ua = lift_tab[hi][k];
            ub = lift_tab[lo][k];
            if (ua != ub) begin
               hi = ua;
               lo = ub;
            end
         end
         meet = lift_tab[hi][0];
      end
      res.ancestor = meet;
      res.distance = tdbl_pkg::DistW'(depth_of[a_in]) + tdbl_pkg::DistW'(depth_of[b_in])
                     - (tdbl_pkg::DistW'(depth_of[meet]) << 1);
      return res;
   endfunction

   function automatic logic [tdbl_pkg::IdW-1:0] any_id();
      return tdbl_pkg::IdW'($urandom_range(NODE_COUNT - 1, 0));
   endfunction

   function automatic logic [tdbl_pkg::IdW-1:0] climb(input logic [tdbl_pkg::IdW-1:0] n,
                                                      input int steps);
      for (int s = 0; s < steps; s++) n = up_of[n];
      return n;
   endfunction

   task automatic queue_op(input logic [tdbl_pkg::OpW-1:0] op,
                           input logic [tdbl_pkg::IdW-1:0] a,
                           input logic [tdbl_pkg::IdW-1:0] b,
                           input logic [tdbl_pkg::DepthW-1:0] d);
      tree_op_type item;
      item.op         = op;
      item.node_a     = a;
      item.node_b     = b;
      item.node_depth = d;
      item.mode       = fill_mode;
      item.hold       = fill_hold;
      fill_hold       = 1'b0;
      pending_ops.insert(pending_ops.size(), item);
   endtask

   task automatic queue_random_query();
      logic [tdbl_pkg::IdW-1:0] a, b;
      a = any_id();
      case ($urandom_range(9))
         0:       b = a;
         1, 2, 3: b = climb(a, $urandom_range(level_of[a], 0));
         4:       b = tree_root;
         5:       b = tree_deep;
         default: b = any_id();
      endcase
      if ($urandom_range(1)) queue_op(tdbl_pkg::OP_QUERY, a, b, tdbl_pkg::DepthW'($urandom));
      else queue_op(tdbl_pkg::OP_QUERY, b, a, tdbl_pkg::DepthW'($urandom));
   endtask

   task automatic plant_tree(input int shape);
      logic [tdbl_pkg::IdW-1:0] node, swap_id;
      int pick, j;
      for (int i = 0; i < NODE_COUNT; i++) order[i] = tdbl_pkg::IdW'(i);
      for (int i = NODE_COUNT - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         swap_id  = order[i];
         order[i] = order[j];
         order[j] = swap_id;
      end
      tree_root = order[0];
      tree_deep = tree_root;
      up_of[tree_root]    = tree_root;
      level_of[tree_root] = '0;
      queue_op(tdbl_pkg::OP_LOAD, tree_root, tree_root, '0);
      for (int k = 1; k < NODE_COUNT; k++) begin
         case (shape)
            SHAPE_MIXED: pick = $urandom_range(1) ? k - 1 : $urandom_range(k - 1, 0);
            SHAPE_PATH:  pick = k - 1;
            SHAPE_BUSHY: pick = $urandom_range(k - 1, 0);
            default:     pick = k - 1;
         endcase
         node = order[k];
         up_of[node]    = order[pick];
         level_of[node] = level_of[order[pick]] + 1'b1;
         if (level_of[node] > level_of[tree_deep]) tree_deep = node;
         queue_op(tdbl_pkg::OP_LOAD, node, up_of[node], level_of[node]);
         if (built_once && $urandom_range(99) == 0) queue_random_query();
      end
      queue_op(tdbl_pkg::OP_BUILD, any_id(), any_id(), tdbl_pkg::DepthW'($urandom));
      built_once = 1'b1;
   endtask

   task automatic queue_random_phase(input int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (i == count / 2)
            queue_op(tdbl_pkg::OP_BUILD, any_id(), any_id(), tdbl_pkg::DepthW'($urandom));
         else if (roll < 85) queue_random_query();
         else if (roll < 95)
            queue_op(tdbl_pkg::OP_LOAD, any_id(), any_id(), tdbl_pkg::DepthW'($urandom));
         else queue_op(OP_UNUSED, any_id(), any_id(), tdbl_pkg::DepthW'($urandom));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.op         <= tdbl_pkg::OP_LOAD;
         req_bus.node_a     <= '0;
         req_bus.node_b     <= '0;
         req_bus.node_depth <= '0;
         rsp_bus.ready      <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
         if (accepted_count == issued_count) begin
            if (pending_ops.size() != 0
                && !(pending_ops[0].hold && expected_paths.size() != 0)
                && $urandom_range(99) >= send_idle) begin
               next_op = pending_ops.pop_front();
               case (next_op.mode)
                  MODE_SLOW_RX: begin
                     send_idle = 23;
                     recv_idle = 54;
                  end
                  MODE_SLOW_TX: begin
                     send_idle = 54;
                     recv_idle = 23;
                  end
                  default: begin
                     send_idle = 0;
                     recv_idle = 0;
                  end
               endcase
               req_bus.op         <= next_op.op;
               req_bus.node_a     <= next_op.node_a;
               req_bus.node_b     <= next_op.node_b;
               req_bus.node_depth <= next_op.node_depth;
               req_bus.valid      <= 1'b1;
               issued_count = issued_count + 1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            accepted_count = accepted_count + 1;
            case (req_bus.op)
               tdbl_pkg::OP_LOAD: begin
                  lift_tab[req_bus.node_a][0] = req_bus.node_b;
                  depth_of[req_bus.node_a]    = req_bus.node_depth;
               end
               tdbl_pkg::OP_BUILD: rebuild_lift_table();
               tdbl_pkg::OP_QUERY:
                  expected_paths.insert(expected_paths.size(),
                                        lca_and_distance(req_bus.node_a, req_bus.node_b));
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_paths.size() == 0) begin
               if (fault_count < 10)
                  $display("Response with no query outstanding: ancestor %0d distance %0d",
                           rsp_bus.ancestor, rsp_bus.distance);
               fault_count = fault_count + 1;
            end else begin
               want_path = expected_paths.pop_front();
               if (rsp_bus.ancestor !== want_path.ancestor
                   || rsp_bus.distance !== want_path.distance) begin
                  if (fault_count < 10)
                     $display("Mismatch: ancestor exp %0d got %0d, distance exp %0d got %0d",
                              want_path.ancestor, rsp_bus.ancestor,
                              want_path.distance, rsp_bus.distance);
                  fault_count = fault_count + 1;
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("tb_tree_distance_by_binary_lifting_top NOT OK");
               $finish;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      built_once = 1'b0;
      fill_mode  = MODE_SLOW_RX;
      fill_hold  = 1'b0;

      plant_tree(SHAPE_MIXED);
      queue_op(tdbl_pkg::OP_QUERY, tree_root, tree_root, '0);
      queue_op(tdbl_pkg::OP_QUERY, tree_root, tree_deep, '1);
      queue_op(tdbl_pkg::OP_QUERY, tree_deep, tree_root, '0);
      queue_op(tdbl_pkg::OP_QUERY, tree_deep, up_of[tree_deep], '0);
      queue_op(tdbl_pkg::OP_QUERY, up_of[tree_deep], tree_deep, '0);
      queue_op(tdbl_pkg::OP_QUERY, '0, '1, '0);
      queue_op(tdbl_pkg::OP_QUERY, '1, '0, '1);
      queue_op(tdbl_pkg::OP_QUERY, tree_deep, order[NODE_COUNT-1], '0);
      queue_op(OP_UNUSED, '1, '1, '1);
      queue_op(OP_UNUSED, '0, '0, '0);
      // A node moved after the build keeps its stale upper levels.
      queue_op(tdbl_pkg::OP_LOAD, order[5], tree_root, 10'd1);
      queue_op(tdbl_pkg::OP_QUERY, order[5], tree_deep, '0);
      queue_op(tdbl_pkg::OP_QUERY, tree_root, order[5], '0);
      // Depths that do not fit the tree make the distance wrap.
      queue_op(tdbl_pkg::OP_LOAD, order[7], order[7], '1);
      queue_op(tdbl_pkg::OP_QUERY, order[7], tree_root, '0);
      queue_op(tdbl_pkg::OP_QUERY, tree_deep, order[7], '0);
      queue_op(tdbl_pkg::OP_LOAD, '1, '1, '1);
      queue_op(tdbl_pkg::OP_LOAD, '0, '0, '0);
      queue_op(tdbl_pkg::OP_QUERY, '0, '1, '0);
      queue_op(tdbl_pkg::OP_QUERY, '1, tree_deep, '0);
      queue_random_phase(125);

      fill_mode = MODE_SLOW_TX;
      fill_hold = 1'b1;
      queue_random_phase(125);

      fill_mode = MODE_FULL;
      fill_hold = 1'b1;
      queue_random_phase(125);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || accepted_count != issued_count
             || expected_paths.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb_tree_distance_by_binary_lifting_top OK");
      end else begin
         $display("tb_tree_distance_by_binary_lifting_top NOT OK");
      end
      $finish;
   end

endmodule
